// ----- rtl/idh_pkg.sv -----
package idh_pkg;

  localparam int NAME_W = 10;
  localparam int NAME_SPACE = 1024;
  localparam int ARITY_W = 4;
  localparam int OP_W = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 11;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_DECREASE = 2'd2;
  localparam logic [OP_W-1:0] OP_EXTRACT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd3;

  localparam logic [ARITY_W-1:0] ARITY_MIN = 4'd2;
  localparam logic [ARITY_W-1:0] ARITY_MAX = 4'd8;

  // clamp arity into the supported range
  function automatic logic [ARITY_W-1:0] eff_arity(input logic [ARITY_W-1:0] a);
    logic [ARITY_W-1:0] r;
    r = a;
    if (a < ARITY_MIN) r = ARITY_MIN;
    if (a > ARITY_MAX) r = ARITY_MAX;
    return r;
  endfunction

endpackage

// ----- rtl/idh_if.sv -----
interface idh_in_if #(parameter int KEY_WIDTH = 64);
  logic valid;
  logic ready;
  logic [idh_pkg::OP_W-1:0] op;
  logic [idh_pkg::NAME_W-1:0] item_name;
  logic [KEY_WIDTH-1:0] item_key;
  modport source(output valid, op, item_name, item_key, input ready);
  modport sink(input valid, op, item_name, item_key, output ready);
endinterface

interface idh_out_if #(parameter int KEY_WIDTH = 64);
  logic valid;
  logic ready;
  logic [idh_pkg::NAME_W-1:0] out_name;
  logic [KEY_WIDTH-1:0] out_key;
  logic [idh_pkg::STATUS_W-1:0] status;
  logic [idh_pkg::COUNT_W-1:0] entry_count_out;
  modport source(output valid, out_name, out_key, status, entry_count_out, input ready);
  modport sink(input valid, out_name, out_key, status, entry_count_out, output ready);
endinterface

// ----- rtl/idh_heap_mem.sv -----
// Heap slot store: key and name per slot, one write and one registered read per cycle.
module idh_heap_mem #(
  parameter int KEY_WIDTH = 64,
  parameter int CAPACITY = 1024,
  parameter int SLOT_W = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [SLOT_W-1:0]         waddr,
  input  logic [KEY_WIDTH-1:0]      wkey,
  input  logic [idh_pkg::NAME_W-1:0] wname,
  input  logic [SLOT_W-1:0]         raddr,
  output logic [KEY_WIDTH-1:0]      rkey,
  output logic [idh_pkg::NAME_W-1:0] rname
);

  logic [KEY_WIDTH+idh_pkg::NAME_W-1:0] mem [CAPACITY+1];
  logic [KEY_WIDTH+idh_pkg::NAME_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wkey, wname};
    rdata_r <= mem[raddr];
  end

  assign rkey = rdata_r[KEY_WIDTH+idh_pkg::NAME_W-1:idh_pkg::NAME_W];
  assign rname = rdata_r[idh_pkg::NAME_W-1:0];

endmodule

// ----- rtl/idh_pos_mem.sv -----
// Name to slot map, with a clearing pass after reset.
module idh_pos_mem #(
  parameter int SLOT_W = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       we,
  input  logic [idh_pkg::NAME_W-1:0] waddr,
  input  logic [SLOT_W-1:0]          wdata,
  input  logic [idh_pkg::NAME_W-1:0] raddr,
  output logic [SLOT_W-1:0]          rdata,
  output logic                       busy
);

  logic [SLOT_W-1:0] mem [idh_pkg::NAME_SPACE];
  logic [idh_pkg::NAME_W:0] clr_r;
  logic [SLOT_W-1:0] rdata_r;

  assign busy = ~clr_r[idh_pkg::NAME_W];

  // clearing pass, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (busy) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) mem[clr_r[idh_pkg::NAME_W-1:0]] <= '0;
    else if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/indexed_dary_min_heap.sv -----
// Indexed d-ary min-heap. Items are taken one at a time, and a new item waits until
// the last result has been taken. Extract and each node of build sift down level by
// level, reading the children one at a time through the single read port of the heap
// slot memory; an accepted decrease sifts up one level at a time. After reset a
// clearing pass runs over the name map before the first item is taken.
module indexed_dary_min_heap #(
  parameter int CAPACITY = 1024,
  parameter int KEY_WIDTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [idh_pkg::ARITY_W-1:0] cfg_wdata,
  idh_in_if.sink   in_ch,
  idh_out_if.source out_ch
);

  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int NW = idh_pkg::NAME_W;
  localparam int CW = idh_pkg::COUNT_W;
  localparam int PW = SLOT_W + idh_pkg::ARITY_W + 1;
  localparam int RW = SLOT_W + 1;
  localparam int PRW = 2 * SLOT_W + 1;

  // reciprocals for the parent divide, exact over the slot range
  localparam logic [RW-1:0] RCP3 = RW'(((1 << (SLOT_W + 2)) + 2) / 3);
  localparam logic [RW-1:0] RCP5 = RW'(((1 << (SLOT_W + 3)) + 4) / 5);
  localparam logic [RW-1:0] RCP6 = RW'(((1 << (SLOT_W + 3)) + 5) / 6);
  localparam logic [RW-1:0] RCP7 = RW'(((1 << (SLOT_W + 3)) + 6) / 7);

  localparam logic [4:0] S_IDLE = 5'd0, S_LOAD = 5'd1, S_DPOS = 5'd2, S_DRD = 5'd3,
    S_DCHK = 5'd4, S_UPRD = 5'd5, S_UPCMP = 5'd6, S_UPWR = 5'd7, S_XRD1 = 5'd8,
    S_XRDN = 5'd9, S_XWR = 5'd10, S_SDRD = 5'd11, S_SDHOLD = 5'd12,
    S_SDCRD = 5'd13, S_SDCMP = 5'd14, S_SDDONE = 5'd15, S_OUT = 5'd16,
    S_BNEXT = 5'd17, S_XSWAP = 5'd18, S_DTEST = 5'd20, S_SDFIRST = 5'd21,
    S_SDDEC = 5'd22, S_SDNEXT = 5'd23;

  logic [4:0] st_r, st_nxt;
  logic [idh_pkg::ARITY_W-1:0] arity_r;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [idh_pkg::OP_W-1:0] op_r;
  logic [NW-1:0] nm_r, nm0_r;
  logic [KEY_WIDTH-1:0] key_r, k0_r, bk_r;
  logic [SLOT_W-1:0] i_r, j_r, last_r, best_r, bi_r;
  logic [KEY_WIDTH-1:0] xk_r;
  logic [NW-1:0] xn_r, bn_r;
  logic [SLOT_W-1:0] pos_r;

  logic [NW-1:0] o_name_r;
  logic [KEY_WIDTH-1:0] o_key_r;
  logic [idh_pkg::STATUS_W-1:0] o_st_r;
  logic o_valid_r;

  // memory ports
  logic hm_we;
  logic [SLOT_W-1:0] hm_waddr, hm_raddr;
  logic [KEY_WIDTH-1:0] hm_wkey, hm_rkey;
  logic [NW-1:0] hm_wname, hm_rname;
  logic pm_we, pm_busy;
  logic [NW-1:0] pm_waddr, pm_raddr;
  logic [SLOT_W-1:0] pm_wdata, pm_rdata;

  idh_heap_mem #(.KEY_WIDTH(KEY_WIDTH), .CAPACITY(CAPACITY), .SLOT_W(SLOT_W)) u_heap (
    .clk(clk), .we(hm_we), .waddr(hm_waddr), .wkey(hm_wkey), .wname(hm_wname),
    .raddr(hm_raddr), .rkey(hm_rkey), .rname(hm_rname));

  idh_pos_mem #(.SLOT_W(SLOT_W)) u_pos (
    .clk(clk), .rst_n(rst_n), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rdata), .busy(pm_busy));

  logic [idh_pkg::ARITY_W-1:0] d;
  logic [PW-1:0] first_w, last_w, parent_w;
  assign d = idh_pkg::eff_arity(arity_r);
  // children of slot i start at (i-1)*d+2
  assign first_w = (PW'(i_r) - PW'(1)) * PW'(d) + PW'(2);
  assign last_w = first_w + PW'(d) - PW'(1);
  // parent of slot i: (i-2)/d+1, by shift or reciprocal multiply
  logic [SLOT_W-1:0] im2;
  logic [RW-1:0] par_rcp;
  logic [PRW-1:0] par_prod;
  logic [PW-1:0] par_q;
  assign im2 = i_r - SLOT_W'(2);
  always_comb begin
    case (d)
      4'd3: par_rcp = RCP3;
      4'd5: par_rcp = RCP5;
      4'd6: par_rcp = RCP6;
      4'd7: par_rcp = RCP7;
      default: par_rcp = '0;
    endcase
  end
  assign par_prod = PRW'(im2) * PRW'(par_rcp);
  always_comb begin
    case (d)
      4'd2: par_q = PW'(im2 >> 1);
      4'd3: par_q = PW'(par_prod >> (SLOT_W + 2));
      4'd4: par_q = PW'(im2 >> 2);
      4'd5, 4'd6, 4'd7: par_q = PW'(par_prod >> (SLOT_W + 3));
      default: par_q = PW'(im2 >> 3);
    endcase
  end
  assign parent_w = par_q + PW'(1);

  assign in_ch.ready = (st_r == S_IDLE) && !pm_busy && !o_valid_r;
  assign out_ch.valid = o_valid_r;
  assign out_ch.out_name = o_name_r;
  assign out_ch.out_key = o_key_r;
  assign out_ch.status = o_st_r;
  assign out_ch.entry_count_out = CW'(cnt_r);

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) arity_r <= idh_pkg::ARITY_MIN;
    else if (cfg_we) arity_r <= cfg_wdata;
  end

  // sequencer datapath
  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    hm_we = 1'b0; hm_waddr = i_r; hm_wkey = k0_r; hm_wname = nm0_r; hm_raddr = i_r;
    pm_we = 1'b0; pm_waddr = nm0_r; pm_wdata = i_r; pm_raddr = nm_r;
    case (st_r)
      S_IDLE: ;
      S_LOAD: begin
        hm_we = 1'b1; hm_waddr = cnt_r; hm_wkey = key_r; hm_wname = nm_r;
        pm_we = 1'b1; pm_waddr = nm_r; pm_wdata = cnt_r;
      end
      S_DPOS: pm_raddr = nm_r;
      S_DRD: hm_raddr = pm_rdata;
      S_UPRD, S_UPCMP: hm_raddr = parent_w[SLOT_W-1:0];
      S_UPWR: begin
        hm_we = 1'b1; hm_waddr = i_r; hm_wkey = hm_rkey; hm_wname = hm_rname;
        pm_we = 1'b1; pm_waddr = hm_rname; pm_wdata = i_r;
      end
      S_XRD1: hm_raddr = SLOT_W'(1);
      S_XRDN: hm_raddr = cnt_r;
      S_XWR: begin
        hm_we = 1'b1; hm_waddr = SLOT_W'(1); hm_wkey = hm_rkey; hm_wname = hm_rname;
        pm_we = 1'b1; pm_waddr = hm_rname; pm_wdata = SLOT_W'(1);
      end
      S_XSWAP: begin
        hm_we = 1'b1; hm_waddr = cnt_r; hm_wkey = xk_r; hm_wname = xn_r;
        pm_we = 1'b1; pm_waddr = xn_r; pm_wdata = cnt_r;
      end
      S_SDRD: hm_raddr = i_r;
      S_SDCRD: hm_raddr = j_r;
      S_SDHOLD: begin
        hm_we = 1'b1; hm_waddr = i_r; hm_wkey = bk_r; hm_wname = bn_r;
        pm_we = 1'b1; pm_waddr = bn_r; pm_wdata = i_r;
      end
      S_SDDONE, S_DCHK: begin
        hm_we = 1'b1; hm_waddr = i_r; hm_wkey = k0_r; hm_wname = nm0_r;
        pm_we = 1'b1; pm_waddr = nm0_r; pm_wdata = i_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      o_valid_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) o_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          op_r <= in_ch.op; nm_r <= in_ch.item_name; key_r <= in_ch.item_key;
          o_name_r <= '0; o_key_r <= '0; o_st_r <= idh_pkg::ST_OK;
          case (in_ch.op)
            idh_pkg::OP_LOAD: begin
              if (cnt_r >= SLOT_W'(CAPACITY)) begin
                o_st_r <= idh_pkg::ST_FULL; st_r <= S_OUT;
              end else begin
                cnt_r <= cnt_r + 1'b1; st_r <= S_LOAD;
              end
            end
            idh_pkg::OP_BUILD: begin
              bi_r <= cnt_r;
              st_r <= S_BNEXT;
            end
            idh_pkg::OP_DECREASE: st_r <= S_DPOS;
            default: begin
              if (cnt_r == '0) begin
                o_st_r <= idh_pkg::ST_EMPTY; st_r <= S_OUT;
              end else st_r <= S_XRD1;
            end
          endcase
        end
        S_LOAD: st_r <= S_OUT;
        S_DPOS: st_r <= S_DRD;
        S_DRD: begin
          pos_r <= pm_rdata; i_r <= pm_rdata;
          st_r <= S_DTEST;
        end
        S_DTEST: begin
          // check presence and key order on the slot just read
          if (pos_r == '0 || pos_r > cnt_r || hm_rname != nm_r || key_r > hm_rkey) begin
            o_st_r <= idh_pkg::ST_REJECT; st_r <= S_OUT;
          end else begin
            k0_r <= key_r; nm0_r <= nm_r;
            st_r <= (i_r > SLOT_W'(1)) ? S_UPRD : S_DCHK;
          end
        end
        S_UPRD: st_r <= S_UPCMP;
        S_UPCMP: begin
          if (hm_rkey > k0_r) st_r <= S_UPWR;
          else st_r <= S_DCHK;
        end
        S_UPWR: begin
          i_r <= parent_w[SLOT_W-1:0];
          st_r <= (parent_w[SLOT_W-1:0] > SLOT_W'(1)) ? S_UPRD : S_DCHK;
        end
        S_DCHK: st_r <= (op_r == idh_pkg::OP_BUILD) ? S_BNEXT : S_OUT;
        S_XRD1: st_r <= S_XRDN;
        S_XRDN: begin
          xk_r <= hm_rkey; xn_r <= hm_rname;
          o_name_r <= hm_rname; o_key_r <= hm_rkey;
          st_r <= S_XWR;
        end
        S_XWR: st_r <= S_XSWAP;
        S_XSWAP: begin
          cnt_r <= cnt_r - 1'b1;
          i_r <= SLOT_W'(1);
          st_r <= (cnt_r - 1'b1 > SLOT_W'(1)) ? S_SDRD : S_OUT;
        end
        S_BNEXT: begin
          if (bi_r == '0) st_r <= S_OUT;
          else begin
            i_r <= bi_r; bi_r <= bi_r - 1'b1; st_r <= S_SDRD;
          end
        end
        S_SDRD: st_r <= S_SDFIRST;
        S_SDFIRST: begin
          k0_r <= hm_rkey; nm0_r <= hm_rname;
          if (first_w > PW'(cnt_r)) st_r <= S_SDDONE;
          else begin
            j_r <= first_w[SLOT_W-1:0];
            best_r <= first_w[SLOT_W-1:0];
            last_r <= (last_w > PW'(cnt_r)) ? cnt_r : last_w[SLOT_W-1:0];
            st_r <= S_SDCRD;
          end
        end
        S_SDCRD: st_r <= S_SDCMP;
        S_SDCMP: begin
          // scan children, keep the first smallest
          if (j_r == best_r || hm_rkey < bk_r) begin
            bk_r <= hm_rkey; bn_r <= hm_rname; best_r <= j_r;
          end
          if (j_r < last_r) begin
            j_r <= j_r + 1'b1; st_r <= S_SDCRD;
          end else st_r <= S_SDDEC;
        end
        S_SDDEC: begin
          if (k0_r > bk_r) st_r <= S_SDHOLD;
          else st_r <= S_SDDONE;
        end
        S_SDHOLD: begin
          i_r <= best_r;
          st_r <= S_SDNEXT;
        end
        S_SDNEXT: begin
          if (first_w > PW'(cnt_r)) st_r <= S_SDDONE;
          else begin
            j_r <= first_w[SLOT_W-1:0];
            best_r <= first_w[SLOT_W-1:0];
            last_r <= (last_w > PW'(cnt_r)) ? cnt_r : last_w[SLOT_W-1:0];
            st_r <= S_SDCRD;
          end
        end
        S_SDDONE: st_r <= (op_r == idh_pkg::OP_BUILD) ? S_BNEXT : S_OUT;
        S_OUT: begin
          o_valid_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // no item taken while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> !in_ch.ready) else $error("item accepted while result pending");
  // count never exceeds capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SLOT_W'(CAPACITY)) else $error("entry count overflow");
  // extract empty leaves the count at zero
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_st_r == idh_pkg::ST_EMPTY) |-> cnt_r == '0)
    else $error("empty status with entries");

endmodule
